>>> rtl/core/sda_pkg.sv
`timescale 1ns / 1ps

package sda_pkg;

  // field widths
  localparam int unsigned AxisW  = 8;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned DzW    = 7;
  localparam int unsigned DelayW = 18;
  localparam int unsigned EventW = 3;

  // packed stream widths, whole bytes
  localparam int unsigned InDataW  = 2 * AxisW + TimeW;
  localparam int unsigned OutDataW = 8;

  // register file decode
  localparam int unsigned AddrW   = 4;
  localparam int unsigned RegIdxW = 2;
  localparam logic [RegIdxW-1:0] RegDeadZone     = 2'd0;
  localparam logic [RegIdxW-1:0] RegInitialDelay = 2'd1;
  localparam logic [RegIdxW-1:0] RegRepeatPeriod = 2'd2;
  localparam logic [RegIdxW-1:0] RegRepeatStep   = 2'd3;

  // register reset values
  localparam logic [DzW-1:0]    DeadZoneRst     = 7'd30;
  localparam logic [DelayW-1:0] InitialDelayRst = 18'd200000;
  localparam logic [DelayW-1:0] RepeatPeriodRst = 18'd30000;
  localparam logic [DelayW-1:0] RepeatStepRst   = 18'd300;

  // navigation event codes
  typedef enum logic [EventW-1:0] {
    DIR_NONE  = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } sda_dir_e;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [DzW-1:0]    dead_zone;
    logic [DelayW-1:0] initial_delay;
    logic [DelayW-1:0] repeat_period;
    logic [DelayW-1:0] repeat_step;
  } sda_cfg_t;

endpackage

>>> rtl/core/sda_dir_pick.sv
`timescale 1ns / 1ps

module sda_dir_pick (
  input  logic signed [sda_pkg::AxisW-1:0] stick_horizontal_i,
  input  logic signed [sda_pkg::AxisW-1:0] stick_vertical_i,
  input  logic [sda_pkg::DzW-1:0]          dead_zone_i,
  output sda_pkg::sda_dir_e                dir_o
);

  logic [sda_pkg::AxisW:0] mag_h;
  logic [sda_pkg::AxisW:0] mag_v;
  logic [sda_pkg::AxisW:0] dz_ext;

  // magnitudes one bit wider so that -128 gives 128
  always_comb begin
    mag_h  = stick_horizontal_i[sda_pkg::AxisW-1]
             ? (~{stick_horizontal_i[sda_pkg::AxisW-1], stick_horizontal_i}) + 1'b1
             : {1'b0, stick_horizontal_i};
    mag_v  = stick_vertical_i[sda_pkg::AxisW-1]
             ? (~{stick_vertical_i[sda_pkg::AxisW-1], stick_vertical_i}) + 1'b1
             : {1'b0, stick_vertical_i};
    dz_ext = {{(sda_pkg::AxisW + 1 - sda_pkg::DzW){1'b0}}, dead_zone_i};
  end

  // dominant axis, ties go to horizontal, then dead zone test
  always_comb begin
    dir_o = sda_pkg::DIR_NONE;
    if (mag_h >= mag_v) begin
      if (mag_h > dz_ext) begin
        dir_o = stick_horizontal_i[sda_pkg::AxisW-1] ? sda_pkg::DIR_LEFT : sda_pkg::DIR_RIGHT;
      end
    end else begin
      if (mag_v > dz_ext) begin
        dir_o = stick_vertical_i[sda_pkg::AxisW-1] ? sda_pkg::DIR_DOWN : sda_pkg::DIR_UP;
      end
    end
  end

endmodule

>>> rtl/core/sda_repeat_ctrl.sv
`timescale 1ns / 1ps

module sda_repeat_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sda_pkg::sda_cfg_t          cfg_i,
  input  logic                       en_i,
  input  sda_pkg::sda_dir_e          dir_i,
  input  logic [sda_pkg::TimeW-1:0]  time_now_i,
  output sda_pkg::sda_dir_e          event_o,
  output sda_pkg::sda_dir_e          held_o
);

  sda_pkg::sda_dir_e             held_q, held_d;
  logic [sda_pkg::TimeW-1:0]     next_q, next_d;
  logic [sda_pkg::DelayW-1:0]    delay_q, delay_d;
  logic [sda_pkg::DelayW-1:0]    delay_new;
  logic [sda_pkg::DelayW-1:0]    arm_delay;
  logic [sda_pkg::TimeW-1:0]     arm_time;
  logic                          is_new;
  logic                          due;

  // delay after a repeat: first repeat loads the period, later ones shrink by the step while above it
  always_comb begin
    if (delay_q == cfg_i.initial_delay) begin
      delay_new = cfg_i.repeat_period;
    end else if (delay_q > cfg_i.repeat_step) begin
      delay_new = delay_q - cfg_i.repeat_step;
    end else begin
      delay_new = delay_q;
    end
  end

  // one shared adder arms the next repeat, wrapping modulo 2^64
  always_comb begin
    is_new    = (dir_i != held_q);
    due       = (time_now_i >= next_q);
    arm_delay = is_new ? cfg_i.initial_delay : delay_new;
    arm_time  = time_now_i + {{(sda_pkg::TimeW - sda_pkg::DelayW){1'b0}}, arm_delay};
  end

  // event and next state
  always_comb begin
    held_d  = held_q;
    next_d  = next_q;
    delay_d = delay_q;
    event_o = sda_pkg::DIR_NONE;
    if (dir_i == sda_pkg::DIR_NONE) begin
      held_d  = sda_pkg::DIR_NONE;
      next_d  = '0;
      delay_d = cfg_i.initial_delay;
    end else if (is_new || due) begin
      held_d  = dir_i;
      delay_d = arm_delay;
      next_d  = arm_time;
      event_o = dir_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= sda_pkg::DIR_NONE;
      next_q  <= '0;
      delay_q <= sda_pkg::InitialDelayRst;
    end else if (en_i) begin
      held_q  <= held_d;
      next_q  <= next_d;
      delay_q <= delay_d;
    end
  end

  assign held_o = held_q;

endmodule

>>> rtl/core/stick_direction_autorepeat_unit.sv
`timescale 1ns / 1ps
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      stick_horizontal, stick_vertical, time_now
// m_axis    out  m_axis_tvalid/tready      nav_event
// apb       in   psel/penable, pready=1    dead_zone, initial_delay, repeat_period, step
//
// One request per cycle sustained while the output is not stalled; a poll's event
// passes the input register, then direction pick, repeat compare and the 64-bit arm
// adder in front of the output register.
// Reset clears the held direction and both valid flags; registers take their defaults.
// A stalled output holds the output register, and the input register keeps one more
// request, so s_axis_tready drops only when both are full.

module stick_direction_autorepeat_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] stick_horizontal, [15:8] stick_vertical, [79:16] time_now
  input  logic [sda_pkg::InDataW-1:0]   s_axis_tdata,
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] nav_event, [7:3] zero
  output logic [sda_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sda_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  sda_pkg::sda_cfg_t               cfg_q;
  logic                            cfg_we;
  logic [sda_pkg::RegIdxW-1:0]     reg_idx;

  logic                            in_valid_q;
  logic signed [sda_pkg::AxisW-1:0] stick_h_q;
  logic signed [sda_pkg::AxisW-1:0] stick_v_q;
  logic [sda_pkg::TimeW-1:0]       time_q;

  logic                            out_valid_q;
  sda_pkg::sda_dir_e               event_q;

  logic                            out_load;
  logic                            advance;
  sda_pkg::sda_dir_e               dir;
  sda_pkg::sda_dir_e               event_d;
  sda_pkg::sda_dir_e               held;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[sda_pkg::AddrW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone     <= sda_pkg::DeadZoneRst;
      cfg_q.initial_delay <= sda_pkg::InitialDelayRst;
      cfg_q.repeat_period <= sda_pkg::RepeatPeriodRst;
      cfg_q.repeat_step   <= sda_pkg::RepeatStepRst;
    end else if (cfg_we) begin
      unique case (reg_idx)
        sda_pkg::RegDeadZone:     cfg_q.dead_zone     <= pwdata[sda_pkg::DzW-1:0];
        sda_pkg::RegInitialDelay: cfg_q.initial_delay <= pwdata[sda_pkg::DelayW-1:0];
        sda_pkg::RegRepeatPeriod: cfg_q.repeat_period <= pwdata[sda_pkg::DelayW-1:0];
        sda_pkg::RegRepeatStep:   cfg_q.repeat_step   <= pwdata[sda_pkg::DelayW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      sda_pkg::RegDeadZone:     prdata = {{(32 - sda_pkg::DzW){1'b0}}, cfg_q.dead_zone};
      sda_pkg::RegInitialDelay: prdata = {{(32 - sda_pkg::DelayW){1'b0}}, cfg_q.initial_delay};
      sda_pkg::RegRepeatPeriod: prdata = {{(32 - sda_pkg::DelayW){1'b0}}, cfg_q.repeat_period};
      sda_pkg::RegRepeatStep:   prdata = {{(32 - sda_pkg::DelayW){1'b0}}, cfg_q.repeat_step};
      default:                  prdata = '0;
    endcase
  end

  // pipeline flow control
  assign out_load      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_load;
  assign s_axis_tready = !in_valid_q || out_load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stick_h_q <= s_axis_tdata[sda_pkg::AxisW-1:0];
      stick_v_q <= s_axis_tdata[2*sda_pkg::AxisW-1:sda_pkg::AxisW];
      time_q    <= s_axis_tdata[sda_pkg::InDataW-1:2*sda_pkg::AxisW];
    end
  end

  sda_dir_pick u_dir_pick (
    .stick_horizontal_i (stick_h_q),
    .stick_vertical_i   (stick_v_q),
    .dead_zone_i        (cfg_q.dead_zone),
    .dir_o              (dir)
  );

  sda_repeat_ctrl u_repeat_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .en_i       (advance),
    .dir_i      (dir),
    .time_now_i (time_q),
    .event_o    (event_d),
    .held_o     (held)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(sda_pkg::OutDataW - sda_pkg::EventW){1'b0}}, event_q};

  // a direction that is emitted becomes the held one
  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (event_d != sda_pkg::DIR_NONE) |=> (held == event_q))
    else $error("emitted direction not held");

  // the input side stalls only with both stages full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // a stalled output freezes the repeat state
  a_stall_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(held))
    else $error("held direction moved during output stall");

endmodule
